@@ rtl/clc_pkg.sv @@
package clc_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int ELEM_W      = 9;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_W-1:0]     count_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data_out;
        logic                     is_empty;
        logic [ELEM_W-1:0]        element_count;
    } out_t;

    // One read and one write port on each of the link and value stores
    typedef struct packed {
        logic   link_we;
        addr_t  link_waddr;
        addr_t  link_wdata;
        addr_t  link_raddr;
        logic   value_we;
        addr_t  value_waddr;
        value_t value_wdata;
        addr_t  value_raddr;
    } store_req_t;

endpackage

@@ rtl/clc_store.sv @@
module clc_store (
    input  logic                clk,
    input  clc_pkg::store_req_t req,
    output clc_pkg::addr_t      link_rdata,
    output clc_pkg::value_t     value_rdata
);
    import clc_pkg::*;

    addr_t  link_mem  [CAPACITY];
    value_t value_mem [CAPACITY];

    addr_t  link_rdata_reg;
    value_t value_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.link_we)
        begin
            link_mem[req.link_waddr] <= req.link_wdata;
        end
        link_rdata_reg <= link_mem[req.link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.value_we)
        begin
            value_mem[req.value_waddr] <= req.value_wdata;
        end
        value_rdata_reg <= value_mem[req.value_raddr];
    end

    assign link_rdata  = link_rdata_reg;
    assign value_rdata = value_rdata_reg;

endmodule

@@ rtl/circular_list_cursor_engine.sv @@
// Circular singly linked list with a cursor, kept in a node store of CAPACITY slots
// (link and value memories, one synchronous read and one write port each). One
// transaction in gives one result out. The sequencer handles one item at a time and
// its length is set by the chain of dependent link reads followed by link write-backs:
// read and advance go through S_READ1 to S_FINISH; insert through S_READ1, S_WRITE1
// and S_FINISH, adding S_WRITE2 when the list is not empty and on top of that S_READ2
// when a released slot goes into a non-empty list; delete through S_READ1, S_READ2,
// S_WRITE1, S_WRITE2 and S_FINISH, skipping S_WRITE2 when the only node is removed;
// an item meeting an empty list or a full store goes from S_IDLE to S_FINISH. The next
// item is accepted while a result still waits in the output register; it only stalls
// in S_FINISH until that result is taken. Slots are reused from a chain of released
// nodes first, then from never-used slots; no clearing pass is needed after reset.
module circular_list_cursor_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  clc_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output clc_pkg::out_t out_item
);
    import clc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ1,
        S_READ2,
        S_WRITE1,
        S_WRITE2,
        S_FINISH
    } state_t;

    state_t  state_reg,       state_next;
    op_t     op_reg,          op_next;
    value_t  value_reg,       value_next;
    status_t status_reg,      status_next;
    value_t  data_reg,        data_next;
    addr_t   slot_reg,        slot_next;
    addr_t   succ_reg,        succ_next;
    addr_t   cursor_reg,      cursor_next;
    logic    empty_reg,       empty_next;
    count_t  count_reg,       count_next;
    count_t  watermark_reg,   watermark_next;
    addr_t   free_head_reg,   free_head_next;
    count_t  freed_count_reg, freed_count_next;
    logic    out_valid_reg,   out_valid_next;
    out_t    out_item_reg,    out_item_next;

    store_req_t req;
    addr_t      link_rdata;
    value_t     value_rdata;

    logic has_freed;
    logic store_full;
    logic [COUNT_W:0] held_slots;

    assign has_freed  = (freed_count_reg != '0);
    assign store_full = !has_freed && (watermark_reg == COUNT_W'(CAPACITY));
    assign held_slots = (COUNT_W+1)'(count_reg) + (COUNT_W+1)'(freed_count_reg);

    clc_store u_store (
        .clk         (clk),
        .req         (req),
        .link_rdata  (link_rdata),
        .value_rdata (value_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        data_next        = data_reg;
        slot_next        = slot_reg;
        succ_next        = succ_reg;
        cursor_next      = cursor_reg;
        empty_next       = empty_reg;
        count_next       = count_reg;
        watermark_next   = watermark_reg;
        free_head_next   = free_head_reg;
        freed_count_next = freed_count_reg;
        out_item_next    = out_item_reg;
        out_valid_next   = out_valid_reg;

        req             = '0;
        req.link_raddr  = cursor_reg;
        req.value_raddr = cursor_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // fetch the next free slot when the chain is not empty, else the cursor's successor
                if (in_item.op == OP_INSERT && has_freed)
                begin
                    req.link_raddr = free_head_reg;
                end
                if (in_valid)
                begin
                    op_next     = in_item.op;
                    value_next  = VALUE_WIDTH'($unsigned(in_item.value));
                    status_next = ST_OK;
                    data_next   = '0;
                    if (in_item.op == OP_INSERT)
                    begin
                        if (store_full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_READ1;
                        end
                    end
                    else if (empty_reg)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ1;
                    end
                end
            end

            S_READ1:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (has_freed)
                        begin
                            slot_next        = free_head_reg;
                            free_head_next   = link_rdata;
                            freed_count_next = freed_count_reg - 1'b1;
                            state_next       = empty_reg ? S_WRITE1 : S_READ2;
                        end
                        else
                        begin
                            slot_next      = watermark_reg[ADDR_W-1:0];
                            watermark_next = watermark_reg + 1'b1;
                            succ_next      = link_rdata;
                            state_next     = S_WRITE1;
                        end
                    end
                    OP_DELETE:
                    begin
                        // victim is the node after the cursor; fetch its link and value
                        slot_next       = link_rdata;
                        req.link_raddr  = link_rdata;
                        req.value_raddr = link_rdata;
                        state_next      = S_READ2;
                    end
                    OP_ADVANCE:
                    begin
                        cursor_next = link_rdata;
                        state_next  = S_FINISH;
                    end
                    OP_READ:
                    begin
                        data_next  = value_rdata;
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_READ2:
            begin
                succ_next = link_rdata;
                if (op_reg == OP_DELETE)
                begin
                    data_next = value_rdata;
                end
                state_next = S_WRITE1;
            end

            S_WRITE1:
            begin
                req.link_we    = 1'b1;
                req.link_waddr = slot_reg;
                if (op_reg == OP_INSERT)
                begin
                    req.value_we    = 1'b1;
                    req.value_waddr = slot_reg;
                    req.value_wdata = value_reg;
                    req.link_wdata  = empty_reg ? slot_reg : succ_reg;
                    if (empty_reg)
                    begin
                        cursor_next = slot_reg;
                        empty_next  = 1'b0;
                        count_next  = count_reg + 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WRITE2;
                    end
                end
                else
                begin
                    // push the victim onto the free chain
                    req.link_wdata   = free_head_reg;
                    free_head_next   = slot_reg;
                    freed_count_next = freed_count_reg + 1'b1;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    if (succ_reg == slot_reg)
                    begin
                        empty_next  = 1'b1;
                        cursor_next = '0;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_WRITE2;
                    end
                end
            end

            S_WRITE2:
            begin
                req.link_we    = 1'b1;
                req.link_waddr = cursor_reg;
                if (op_reg == OP_INSERT)
                begin
                    req.link_wdata = slot_reg;
                    count_next     = count_reg + 1'b1;
                end
                else
                begin
                    req.link_wdata = succ_reg;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.status        = status_reg;
                    out_item_next.data_out      = DATA_W'(signed'(data_reg));
                    out_item_next.is_empty      = empty_reg;
                    out_item_next.element_count = ELEM_W'(count_reg);
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_INSERT;
            value_reg       <= '0;
            status_reg      <= ST_OK;
            data_reg        <= '0;
            slot_reg        <= '0;
            succ_reg        <= '0;
            cursor_reg      <= '0;
            empty_reg       <= 1'b1;
            count_reg       <= '0;
            watermark_reg   <= '0;
            free_head_reg   <= '0;
            freed_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            value_reg       <= value_next;
            status_reg      <= status_next;
            data_reg        <= data_next;
            slot_reg        <= slot_next;
            succ_reg        <= succ_next;
            cursor_reg      <= cursor_next;
            empty_reg       <= empty_next;
            count_reg       <= count_next;
            watermark_reg   <= watermark_next;
            free_head_reg   <= free_head_next;
            freed_count_reg <= freed_count_next;
            out_valid_reg   <= out_valid_next;
            out_item_reg    <= out_item_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (count_reg == '0))
        else $error("empty flag disagrees with node count");

    a_slots_accounted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> held_slots == (COUNT_W+1)'(watermark_reg))
        else $error("listed plus released slots differ from slots ever used");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status == ST_FULL
            |-> out_item_reg.element_count == ELEM_W'(CAPACITY))
        else $error("store reported full below capacity");

endmodule

@@ tb/circular_list_cursor_engine_tb.sv @@
`timescale 1ns / 100ps

module circular_list_cursor_engine_tb;

    import clc_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_item;
    logic out_valid;
    logic out_ready;
    out_t out_item;

    // Own copy of the list held by the block
    value_t node_val [CAPACITY];
    addr_t  node_link [CAPACITY];
    addr_t  cur;
    logic   list_empty;
    count_t node_count;
    count_t watermark;
    addr_t  free_head;
    count_t freed_cnt;

    out_t due_replies [$];
    out_t want_reply;

    int failures;
    int replies_seen;
    int op_seen [4];
    int full_seen;
    int empty_seen;
    bit tx_idle_en;
    bit rx_idle_en;
    int hold_off;

    circular_list_cursor_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Apply one operation to the list copy and work out the reply
    function automatic out_t apply_list_op(in_t item);
        out_t  r;
        addr_t n;
        addr_t t;
        addr_t after;
        logic  got;
        r = '0;
        r.status = ST_OK;
        n = '0;
        got = 1'b1;
        if (item.op == OP_INSERT)
        begin
            if (freed_cnt != 0)
            begin
                n = free_head;
                free_head = node_link[n];
                freed_cnt--;
            end
            else if (watermark < CAPACITY)
            begin
                n = addr_t'(watermark);
                watermark++;
            end
            else
                got = 1'b0;
            if (!got)
                r.status = ST_FULL;
            else
            begin
                node_val[n] = item.value[VALUE_WIDTH-1:0];
                if (list_empty)
                begin
                    node_link[n] = n;
                    cur = n;
                    list_empty = 1'b0;
                end
                else
                begin
                    node_link[n] = node_link[cur];
                    node_link[cur] = n;
                end
                node_count++;
            end
        end
        else if (list_empty)
            r.status = ST_EMPTY;
        else if (item.op == OP_DELETE)
        begin
            t = node_link[cur];
            after = node_link[t];
            r.data_out = DATA_W'($signed(node_val[t]));
            if (after == t)
            begin
                list_empty = 1'b1;
                cur = '0;
            end
            else
                node_link[cur] = after;
            node_link[t] = free_head;
            free_head = t;
            freed_cnt++;
            if (node_count != 0)
                node_count--;
        end
        else if (item.op == OP_ADVANCE)
            cur = node_link[cur];
        else
            r.data_out = DATA_W'($signed(node_val[cur]));
        r.is_empty = list_empty;
        r.element_count = ELEM_W'(node_count);
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_item(op_t op, logic signed [DATA_W-1:0] value);
        in_t item;
        int  gap;
        item.op = op;
        item.value = value;
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        want_reply = apply_list_op(item);
        due_replies.push_back(want_reply);
        op_seen[item.op]++;
        if (want_reply.status == ST_FULL)
            full_seen++;
        if (want_reply.status == ST_EMPTY)
            empty_seen++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void diff_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : reply_check
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (due_replies.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %p",
                         $time, out_item);
                failures++;
            end
            else
            begin
                want = due_replies.pop_front();
                diff_field("status", int'(want.status), int'(out_item.status));
                diff_field("data_out", want.data_out, out_item.data_out);
                diff_field("is_empty", want.is_empty, out_item.is_empty);
                diff_field("element_count", want.element_count, out_item.element_count);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off) @(negedge clk);
                hold_off = 0;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 20)
            begin
                out_ready <= 1'b0;
                stall = pick_gap() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_empty_list();
        send_item(OP_READ, 32'sd5);
        send_item(OP_DELETE, -32'sd1);
        send_item(OP_ADVANCE, 32'sd0);
    endtask

    task automatic test_single_node();
        send_item(OP_INSERT, 32'sh7fffffff);
        send_item(OP_READ, 32'sd0);
        send_item(OP_ADVANCE, 32'sd0);
        send_item(OP_READ, 32'sd0);
        // Remove the only node: list goes empty, cursor back to slot zero
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_READ, 32'sd0);
    endtask

    task automatic test_value_extremes();
        send_item(OP_INSERT, 32'sh80000000);
        send_item(OP_INSERT, 32'sd0);
        send_item(OP_INSERT, -32'sd1);
        send_item(OP_INSERT, 32'sh55555555);
        send_item(OP_INSERT, 32'shaaaaaaaa);
        send_item(OP_READ, 32'sd0);
        repeat (3) send_item(OP_ADVANCE, 32'sd0);
        send_item(OP_READ, 32'sd0);
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_READ, 32'sd0);
    endtask

    task automatic test_fill_and_drain();
        while (node_count < CAPACITY)
            send_item(OP_INSERT, $urandom());
        send_item(OP_INSERT, $urandom());
        send_item(OP_READ, 32'sd0);
        // Free one node and take it back, then hit the full store again
        send_item(OP_DELETE, 32'sd0);
        send_item(OP_INSERT, $urandom());
        send_item(OP_INSERT, $urandom());
        send_item(OP_ADVANCE, 32'sd0);
        // Release a run of nodes onto the free chain, then reuse a few
        repeat (40) send_item(OP_DELETE, 32'sd0);
        repeat (3) send_item(OP_INSERT, $urandom());
        send_item(OP_READ, 32'sd0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic op_t pick_op();
        int r;
        int ins;
        int del;
        r = $urandom_range(0, 99);
        ins = (node_count == 0) ? 60 : (node_count < 6) ? 45 : 35;
        del = (node_count < 6) ? 25 : 35;
        if (r < ins)
            return OP_INSERT;
        if (r < ins + del)
            return OP_DELETE;
        if (r < ins + del + (100 - ins - del) / 2)
            return OP_ADVANCE;
        return OP_READ;
    endfunction

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        hold_off = 150;
        // Keep offering while the receiver holds off; the block must stall its input
        repeat (30) send_item(pick_op(), pick_value());
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_ops();
        for (int i = 0; i < 100; i++)
        begin
            // Alternate stretches with and without idling on either side
            tx_idle_en = ((i / 20) % 3) != 1;
            rx_idle_en = ((i / 25) % 4) != 2;
            send_item(pick_op(), pick_value());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        failures = 0;
        replies_seen = 0;
        full_seen = 0;
        empty_seen = 0;
        hold_off = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (op_seen[i])
            op_seen[i] = 0;
        foreach (node_val[i])
        begin
            node_val[i] = '0;
            node_link[i] = '0;
        end
        cur = '0;
        list_empty = 1'b1;
        node_count = '0;
        watermark = '0;
        free_head = '0;
        freed_cnt = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_single_node();
        test_value_extremes();
        test_fill_and_drain();
        test_output_backpressure();
        test_random_ops();
        wait_drained();

        if (due_replies.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, due_replies.size());
            failures++;
        end
        $display("covered %0d transactions: %0d insert, %0d delete, %0d advance, %0d read",
                 replies_seen, op_seen[OP_INSERT], op_seen[OP_DELETE],
                 op_seen[OP_ADVANCE], op_seen[OP_READ]);
        $display("store full reported %0d times, empty list %0d times, %0d mismatches",
                 full_seen, empty_seen, failures);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/clc_pkg.sv
rtl/clc_store.sv
rtl/circular_list_cursor_engine.sv
tb/circular_list_cursor_engine_tb.sv
